// File: hdl/belady_opt_cache_engine_macros.svh
// Assertion macros used by the port-level checker of the OPT cache engine.
`ifndef BELADY_OPT_CACHE_ENGINE_MACROS_SVH
`define BELADY_OPT_CACHE_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BOE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BOE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/boe_pkg.sv
// Types, constants and codes shared by the OPT cache engine modules.
`default_nettype none

package boe_pkg;

	localparam int MAX_ENTRIES   = 64;
	localparam int SLOT_BITS     = $clog2(MAX_ENTRIES);
	localparam int OCC_BITS      = SLOT_BITS + 1;
	localparam int ID_BITS       = 16;
	localparam int TIME_BITS     = 32;
	localparam int CNT_BITS      = 40;
	localparam int CAP_BITS      = 7;
	localparam int CMP_BITS      = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;
	localparam int SEEN_BIT_BITS = 5;
	localparam int SEEN_WORD     = 2 ** SEEN_BIT_BITS;
	localparam int SEEN_ROW_BITS = ID_BITS - SEEN_BIT_BITS;
	localparam int SEEN_ROWS     = 2 ** SEEN_ROW_BITS;

	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(64);

	typedef enum logic [1:0] {
		OUT_HIT  = 2'd0,
		OUT_CAP  = 2'd1,
		OUT_COLD = 2'd2
	} outcome_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   block_id;
		logic [TIME_BITS-1:0] current_time;
		logic [TIME_BITS-1:0] next_use;
	} req_t;

	typedef struct packed {
		outcome_t              outcome;
		logic                  evicted_valid;
		logic [ID_BITS-1:0]    evicted_id;
		logic [CNT_BITS-1:0]   hits_total;
		logic [CNT_BITS-1:0]   misses_total;
		logic [CNT_BITS-1:0]   cold_misses_total;
	} rsp_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   block;
		logic [TIME_BITS-1:0] next_use;
	} entry_t;

	typedef struct packed {
		logic                 wr_en;
		logic [SLOT_BITS-1:0] waddr;
		logic [SLOT_BITS-1:0] raddr;
		entry_t               wdata;
	} entry_req_t;

	typedef struct packed {
		logic                     rd_en;
		logic                     wr_en;
		logic [SEEN_ROW_BITS-1:0] row;
		logic [SEEN_WORD-1:0]     wdata;
	} seen_req_t;

endpackage

`default_nettype wire

// File: hdl/belady_opt_cache_engine.sv
// Top level of the Belady OPT replacement cache engine.
`default_nettype none

// The engine takes no new request while one is in flight: the sequencer reads
// the 64-entry slot memory one entry per cycle through its single read port,
// looking for a hit, the farthest next use and the first free slot, then
// drains the last read and decides in its DRAIN and DONE states; the result
// strobe follows, and a new request may be started in that strobe cycle. The
// result is shown for one cycle only and must be taken then. After reset, busy
// stays high while the seen bitmap is cleared one row per cycle; capacity
// writes take effect at once, so make them while no request is in flight.
module belady_opt_cache_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire boe_pkg::req_t                 request,
	input  wire logic                          cfg_we,
	input  wire logic [boe_pkg::CAP_BITS-1:0]  cfg_wdata,
	output logic                               result_valid,
	output boe_pkg::rsp_t                      result
);

	boe_pkg::entry_req_t             entry_req;
	boe_pkg::entry_t                 entry_rdata;
	boe_pkg::seen_req_t              seen_req;
	logic [boe_pkg::SEEN_WORD-1:0]   seen_rdata;
	logic                            seen_ready;

	boe_entry_store u_entry_store (
		.clk   (clk),
		.req   (entry_req),
		.rdata (entry_rdata)
	);

	boe_seen_map u_seen_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (seen_req),
		.rdata  (seen_rdata),
		.ready  (seen_ready)
	);

	boe_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result       (result),
		.entry_req    (entry_req),
		.entry_rdata  (entry_rdata),
		.seen_req     (seen_req),
		.seen_rdata   (seen_rdata),
		.seen_ready   (seen_ready)
	);

endmodule

`default_nettype wire

// File: hdl/boe_entry_store.sv
// Cache entry memory: block id and next use per slot, registered read.
`default_nettype none

module boe_entry_store (
	input  wire logic                clk,
	input  wire boe_pkg::entry_req_t req,
	output boe_pkg::entry_t          rdata
);

	boe_pkg::entry_t mem [boe_pkg::MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

`default_nettype wire

// File: hdl/boe_seen_map.sv
// Seen bitmap memory, 32 ids per row, with a clearing pass after reset.
`default_nettype none

module boe_seen_map (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire boe_pkg::seen_req_t                  req,
	output logic [boe_pkg::SEEN_WORD-1:0]            rdata,
	output logic                                     ready
);

	logic [boe_pkg::SEEN_WORD-1:0]     mem [boe_pkg::SEEN_ROWS];
	logic [boe_pkg::SEEN_ROW_BITS-1:0] clr_addr_q;
	logic                              clr_done_q;
	logic                              we;
	logic [boe_pkg::SEEN_ROW_BITS-1:0] waddr;
	logic [boe_pkg::SEEN_WORD-1:0]     wdata;

	assign ready = clr_done_q;

	always_comb begin
		we    = !clr_done_q || req.wr_en;
		waddr = clr_done_q ? req.row : clr_addr_q;
		wdata = clr_done_q ? req.wdata : '0;
	end

	// Sweep every row to zero once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (req.rd_en) begin
			rdata <= mem[req.row];
		end
	end

endmodule

`default_nettype wire

// File: hdl/boe_ctrl.sv
// Sequencer: scans the entry memory, picks hit or victim, updates state.
`default_nettype none

module boe_ctrl (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire boe_pkg::req_t                     request,
	input  wire logic                              cfg_we,
	input  wire logic [boe_pkg::CAP_BITS-1:0]      cfg_wdata,
	output logic                                   result_valid,
	output boe_pkg::rsp_t                          result,
	output boe_pkg::entry_req_t                    entry_req,
	input  wire boe_pkg::entry_t                   entry_rdata,
	output boe_pkg::seen_req_t                     seen_req,
	input  wire logic [boe_pkg::SEEN_WORD-1:0]     seen_rdata,
	input  wire logic                              seen_ready
);

	localparam logic [boe_pkg::SLOT_BITS-1:0] LAST_SLOT =
		boe_pkg::SLOT_BITS'(boe_pkg::MAX_ENTRIES - 1);
	localparam logic [boe_pkg::CAP_BITS-1:0] CAP_MAX =
		boe_pkg::CAP_BITS'(boe_pkg::MAX_ENTRIES);

	boe_pkg::state_t state_q, state_d;

	logic [boe_pkg::CAP_BITS-1:0]    cap_q;
	logic [boe_pkg::CAP_BITS-1:0]    cap_eff;
	logic [boe_pkg::SLOT_BITS-1:0]   scan_addr_q;
	logic [boe_pkg::SLOT_BITS-1:0]   idx_s1;
	logic                            vld_s1;
	logic [boe_pkg::MAX_ENTRIES-1:0] valid_q;
	logic [boe_pkg::OCC_BITS-1:0]    occ_q;
	logic [boe_pkg::CNT_BITS-1:0]    hit_cnt_q, miss_cnt_q, cold_cnt_q;

	logic [boe_pkg::ID_BITS-1:0]     id_q;
	logic [boe_pkg::TIME_BITS-1:0]   nu_q;

	logic                            match_found_q, best_found_q, free_found_q;
	logic [boe_pkg::SLOT_BITS-1:0]   match_slot_q, best_slot_q, free_slot_q;
	logic [boe_pkg::TIME_BITS-1:0]   best_nu_q;
	logic [boe_pkg::ID_BITS-1:0]     best_block_q;

	boe_pkg::rsp_t                   rsp_q;
	logic                            rsp_valid_q;

	logic                            cur_valid;
	logic                            seen_bit;
	logic                            evict;
	logic                            slot_ok;
	logic [boe_pkg::SLOT_BITS-1:0]   use_slot;
	logic [boe_pkg::SLOT_BITS-1:0]   wr_slot;
	boe_pkg::outcome_t               outcome;

	assign result_valid = rsp_valid_q;
	assign result       = rsp_q;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = boe_pkg::CAP_BITS'(1);
		end else if (cap_q > CAP_MAX) begin
			cap_eff = CAP_MAX;
		end else begin
			cap_eff = cap_q;
		end
	end

	// Decision at the end of the scan.
	always_comb begin
		cur_valid = valid_q[idx_s1];
		seen_bit  = seen_rdata[id_q[boe_pkg::SEEN_BIT_BITS-1:0]];
		evict     = !match_found_q && best_found_q &&
			(boe_pkg::CMP_BITS'(occ_q) >= boe_pkg::CMP_BITS'(cap_eff));
		slot_ok   = evict || free_found_q;
		use_slot  = evict ? best_slot_q : free_slot_q;
		wr_slot   = match_found_q ? match_slot_q : use_slot;
		if (match_found_q) begin
			outcome = boe_pkg::OUT_HIT;
		end else if (seen_bit) begin
			outcome = boe_pkg::OUT_CAP;
		end else begin
			outcome = boe_pkg::OUT_COLD;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			boe_pkg::ST_CLEAR: begin
				if (seen_ready) begin
					state_d = boe_pkg::ST_IDLE;
				end
			end
			boe_pkg::ST_IDLE: begin
				if (start) begin
					state_d = boe_pkg::ST_SCAN;
				end
			end
			boe_pkg::ST_SCAN: begin
				if (scan_addr_q == LAST_SLOT) begin
					state_d = boe_pkg::ST_DRAIN;
				end
			end
			boe_pkg::ST_DRAIN: state_d = boe_pkg::ST_DONE;
			boe_pkg::ST_DONE:  state_d = boe_pkg::ST_IDLE;
			default:           state_d = boe_pkg::ST_CLEAR;
		endcase
	end

	// Outputs toward the memories.
	always_comb begin
		busy               = 1'b1;
		entry_req.wr_en    = 1'b0;
		entry_req.waddr    = wr_slot;
		entry_req.raddr    = scan_addr_q;
		entry_req.wdata    = '{block: id_q, next_use: nu_q};
		seen_req.rd_en     = 1'b0;
		seen_req.wr_en     = 1'b0;
		seen_req.row       = id_q[boe_pkg::ID_BITS-1:boe_pkg::SEEN_BIT_BITS];
		seen_req.wdata     = seen_rdata |
			(boe_pkg::SEEN_WORD'(1) << id_q[boe_pkg::SEEN_BIT_BITS-1:0]);
		unique case (state_q)
			boe_pkg::ST_IDLE: begin
				busy           = 1'b0;
				seen_req.rd_en = start;
				seen_req.row   =
					request.block_id[boe_pkg::ID_BITS-1:boe_pkg::SEEN_BIT_BITS];
			end
			boe_pkg::ST_DONE: begin
				entry_req.wr_en = match_found_q || slot_ok;
				seen_req.wr_en  = !match_found_q && !seen_bit;
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= boe_pkg::ST_CLEAR;
			cap_q         <= boe_pkg::CAP_RESET;
			scan_addr_q   <= '0;
			vld_s1        <= 1'b0;
			valid_q       <= '0;
			occ_q         <= '0;
			hit_cnt_q     <= '0;
			miss_cnt_q    <= '0;
			cold_cnt_q    <= '0;
			rsp_valid_q   <= 1'b0;
			match_found_q <= 1'b0;
			best_found_q  <= 1'b0;
			free_found_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			vld_s1      <= (state_q == boe_pkg::ST_SCAN);
			rsp_valid_q <= (state_q == boe_pkg::ST_DONE);
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (state_q == boe_pkg::ST_IDLE) begin
				scan_addr_q   <= '0;
				match_found_q <= 1'b0;
				best_found_q  <= 1'b0;
				free_found_q  <= 1'b0;
			end
			if (state_q == boe_pkg::ST_SCAN) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			if (vld_s1) begin
				if (cur_valid && entry_rdata.block == id_q && !match_found_q) begin
					match_found_q <= 1'b1;
				end
				if (cur_valid && (!best_found_q || entry_rdata.next_use > best_nu_q)) begin
					best_found_q <= 1'b1;
				end
				if (!cur_valid && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (state_q == boe_pkg::ST_DONE) begin
				if (match_found_q) begin
					hit_cnt_q <= (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;
				end else begin
					if (seen_bit) begin
						miss_cnt_q <= (miss_cnt_q == '1) ? miss_cnt_q : miss_cnt_q + 1'b1;
					end else begin
						cold_cnt_q <= (cold_cnt_q == '1) ? cold_cnt_q : cold_cnt_q + 1'b1;
					end
					if (slot_ok) begin
						valid_q[use_slot] <= 1'b1;
					end
					// Admit into a free slot grows occupancy; replacing does not.
					if (!evict && free_found_q) begin
						occ_q <= occ_q + 1'b1;
					end
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= scan_addr_q;
		if (state_q == boe_pkg::ST_IDLE && start) begin
			id_q <= request.block_id;
			nu_q <= request.next_use;
		end
		if (vld_s1) begin
			if (cur_valid && entry_rdata.block == id_q && !match_found_q) begin
				match_slot_q <= idx_s1;
			end
			if (cur_valid && (!best_found_q || entry_rdata.next_use > best_nu_q)) begin
				best_slot_q  <= idx_s1;
				best_nu_q    <= entry_rdata.next_use;
				best_block_q <= entry_rdata.block;
			end
			if (!cur_valid && !free_found_q) begin
				free_slot_q <= idx_s1;
			end
		end
		if (state_q == boe_pkg::ST_DONE) begin
			rsp_q.outcome           <= outcome;
			rsp_q.evicted_valid     <= evict;
			rsp_q.evicted_id        <= evict ? best_block_q : '0;
			rsp_q.hits_total        <= (match_found_q && hit_cnt_q != '1) ?
				hit_cnt_q + 1'b1 : hit_cnt_q;
			rsp_q.misses_total      <= (!match_found_q && seen_bit && miss_cnt_q != '1) ?
				miss_cnt_q + 1'b1 : miss_cnt_q;
			rsp_q.cold_misses_total <= (!match_found_q && !seen_bit && cold_cnt_q != '1) ?
				cold_cnt_q + 1'b1 : cold_cnt_q;
		end
	end

endmodule

`default_nettype wire

// File: hdl/boe_checker.sv
// Port-level checks for the OPT cache engine, bound to the top level.
`default_nettype none

`include "belady_opt_cache_engine_macros.svh"

module boe_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire boe_pkg::rsp_t result,
	input wire logic          result_valid
);

	`BOE_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`BOE_ASSERT_NEXT(a_single_strobe, clk, arst_n, result_valid, !result_valid)
	`BOE_ASSERT_NOW(a_evict_id_zero, clk, arst_n, result_valid && !result.evicted_valid, result.evicted_id == '0)
	`BOE_ASSERT_NOW(a_evict_on_miss, clk, arst_n, result_valid && result.evicted_valid, result.outcome != boe_pkg::OUT_HIT)
	`BOE_ASSERT_NOW(a_outcome_code, clk, arst_n, result_valid, result.outcome == boe_pkg::OUT_HIT || result.outcome == boe_pkg::OUT_CAP || result.outcome == boe_pkg::OUT_COLD)

endmodule

bind belady_opt_cache_engine boe_checker u_boe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result       (result),
	.result_valid (result_valid)
);

`default_nettype wire

// File: test/boe_opt_checker.sv
// Checker for the OPT cache engine: tracks requests, predicts results and compares them.
module boe_opt_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  boe_pkg::req_t                  request,
	input  logic                           cfg_we,
	input  logic [boe_pkg::CAP_BITS-1:0]   cfg_wdata,
	input  logic                           result_valid,
	input  boe_pkg::rsp_t                  result,
	output int                             mismatches,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import boe_pkg::*;

	localparam int PRINT_CAP = 200;

	// shadow of the engine state
	logic [CAP_BITS-1:0]   capacity;
	bit                    slot_valid [MAX_ENTRIES];
	logic [ID_BITS-1:0]    slot_block [MAX_ENTRIES];
	logic [TIME_BITS-1:0]  slot_next  [MAX_ENTRIES];
	logic [2**ID_BITS-1:0] seen_ids;
	int                    occupancy;
	logic [CNT_BITS-1:0]   hit_cnt;
	logic [CNT_BITS-1:0]   miss_cnt;
	logic [CNT_BITS-1:0]   cold_cnt;

	rsp_t due_rsp [$];
	rsp_t want;
	int   rsp_seen;

	function automatic logic [CNT_BITS-1:0] bump(input logic [CNT_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// Advance the shadow state by one request and return the result it must give.
	function automatic rsp_t belady_access(input req_t r);
		rsp_t                 p;
		int                   hit_slot;
		int                   slot;
		int                   limit;
		logic [TIME_BITS-1:0] farthest;
		p        = '0;
		hit_slot = -1;
		slot     = -1;
		farthest = '0;
		limit    = (capacity == 0) ? 1 : ((capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity);
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (hit_slot < 0 && slot_valid[i] && slot_block[i] == r.block_id)
				hit_slot = i;
		if (hit_slot >= 0) begin
			p.outcome = OUT_HIT;
			hit_cnt = bump(hit_cnt);
			slot_next[hit_slot] = r.next_use;
		end else begin
			if (seen_ids[r.block_id]) begin
				p.outcome = OUT_CAP;
				miss_cnt = bump(miss_cnt);
			end else begin
				p.outcome = OUT_COLD;
				cold_cnt = bump(cold_cnt);
				seen_ids[r.block_id] = 1'b1;
			end
			// farthest next use loses its slot; strict compare picks the lowest slot on ties
			if (occupancy >= limit) begin
				for (int i = 0; i < MAX_ENTRIES; i++)
					if (slot_valid[i] && (slot < 0 || slot_next[i] > farthest)) begin
						slot     = i;
						farthest = slot_next[i];
					end
				if (slot >= 0) begin
					p.evicted_valid = 1'b1;
					p.evicted_id    = slot_block[slot];
				end
			end
			if (slot < 0) begin
				for (int i = 0; i < MAX_ENTRIES; i++)
					if (slot < 0 && !slot_valid[i])
						slot = i;
				if (slot >= 0)
					occupancy++;
			end
			if (slot >= 0) begin
				slot_valid[slot] = 1'b1;
				slot_block[slot] = r.block_id;
				slot_next[slot]  = r.next_use;
			end
		end
		p.hits_total        = hit_cnt;
		p.misses_total      = miss_cnt;
		p.cold_misses_total = cold_cnt;
		return p;
	endfunction

	task automatic report(input string what);
		if (mismatches < PRINT_CAP)
			$display("[%0t] result %0d: %s", $realtime, rsp_seen, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity   = CAP_RESET;
			seen_ids   = '0;
			occupancy  = 0;
			hit_cnt    = '0;
			miss_cnt   = '0;
			cold_cnt   = '0;
			rsp_seen   = 0;
			mismatches = 0;
			foreach (slot_valid[i]) begin
				slot_valid[i] = 1'b0;
				slot_block[i] = '0;
				slot_next[i]  = '0;
			end
			due_rsp.delete();
			outstanding = 0;
		end else begin
			if (result_valid) begin
				if (due_rsp.size() == 0) begin
					report("result strobe with no request outstanding");
				end else begin
					want = due_rsp.pop_front();
					if (result.outcome !== want.outcome)
						report($sformatf("outcome %0d, want %0d", result.outcome, want.outcome));
					if (result.evicted_valid !== want.evicted_valid)
						report($sformatf("evicted_valid %b, want %b",
							result.evicted_valid, want.evicted_valid));
					if (result.evicted_id !== want.evicted_id)
						report($sformatf("evicted_id %h, want %h",
							result.evicted_id, want.evicted_id));
					if (result.hits_total !== want.hits_total)
						report($sformatf("hits_total %0d, want %0d",
							result.hits_total, want.hits_total));
					if (result.misses_total !== want.misses_total)
						report($sformatf("misses_total %0d, want %0d",
							result.misses_total, want.misses_total));
					if (result.cold_misses_total !== want.cold_misses_total)
						report($sformatf("cold_misses_total %0d, want %0d",
							result.cold_misses_total, want.cold_misses_total));
				end
				rsp_seen++;
			end
			if (start && !busy)
				due_rsp.insert(due_rsp.size(), belady_access(request));
			if (cfg_we)
				capacity = cfg_wdata;
			outstanding = due_rsp.size();
		end
	end

endmodule

// File: test/tb_belady_opt_cache_engine.sv
// Testbench top for the OPT cache engine: stimulus, capacity phases and the verdict.
module tb_belady_opt_cache_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import boe_pkg::*;

	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 130;
	localparam int TAIL_CYCLES = 80;
	localparam int CYCLE_LIMIT = 800_000;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	req_t                request   = '0;
	logic                cfg_we    = 1'b0;
	logic [CAP_BITS-1:0] cfg_wdata = '0;
	logic                busy;
	logic                result_valid;
	rsp_t                result;
	int                  mismatches;
	int                  outstanding;
	int                  cycles    = 0;

	belady_opt_cache_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result       (result)
	);

	boe_opt_checker opt_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Present one request and hold it until the engine takes it.
	task automatic access(input logic [ID_BITS-1:0] id, input logic [TIME_BITS-1:0] ct,
			input logic [TIME_BITS-1:0] nu);
		@(negedge clk);
		start                <= 1'b1;
		request.block_id     <= id;
		request.current_time <= ct;
		request.next_use     <= nu;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic hold_off(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_BITS-1:0] v);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		logic [CAP_BITS-1:0]  cap;
		logic [ID_BITS-1:0]   pool;
		logic [ID_BITS-1:0]   id;
		logic [TIME_BITS-1:0] trace_pos;
		logic [TIME_BITS-1:0] tie_base;
		logic [TIME_BITS-1:0] ct;
		logic [TIME_BITS-1:0] nu;
		int                   eff;
		int                   span;
		int                   burst;
		int                   pick;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// cold misses at the id and time extremes, then a hit refresh
		access(16'h0000, 32'h0000_0000, 32'h0000_0000);
		access(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		access(16'h0000, 32'h0000_0001, 32'd5);
		set_capacity(7'd2);
		// full cache: evict the never-again block, then bring it back as a capacity miss
		access(16'h1234, 32'd2, 32'd100);
		access(16'hFFFF, 32'd3, 32'd50);
		// equal next uses on both slots: the lower slot goes
		access(16'h0000, 32'd4, 32'd77);
		access(16'hFFFF, 32'd5, 32'd77);
		access(16'h0003, 32'd6, 32'd9);
		access(16'h0000, 32'd7, 32'h40);
		// zero capacity acts as one, below the current occupancy of two
		set_capacity(7'd0);
		access(16'h0007, 32'd8, 32'd1);
		access(16'h0003, 32'd9, 32'd9);
		access(16'h0000, 32'd10, 32'd2);
		// oversized capacity clamps to the slot count
		set_capacity(7'd127);
		access(16'hAAAA, 32'hAAAA_AAAA, 32'h8000_0000);
		access(16'h5555, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		access(16'h0007, 32'h5555_5555, 32'hFFFF_FFFE);
		set_capacity(7'd1);
		access(16'h8001, 32'h8000_0001, 32'h1234_5678);
		access(16'hAAAA, 32'h8000_0002, 32'hFFFF_FFFF);

		burst     = 0;
		trace_pos = $urandom;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: cap = 7'd1;
				1: cap = 7'd64;
				2: cap = 7'd0;
				3: cap = 7'd3;
				4: cap = 7'd127;
				5: cap = 7'd8;
				6: cap = 7'd65;
				7: cap = 7'd2;
				default: cap = CAP_BITS'($urandom_range(0, 127));
			endcase
			set_capacity(cap);
			eff      = (cap == 0) ? 1 : ((cap > MAX_ENTRIES) ? MAX_ENTRIES : cap);
			// working set a bit larger than the cache so hits and evictions both occur
			span     = eff + $urandom_range(1, eff + 6);
			pool     = $urandom;
			tie_base = $urandom;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst == 0) begin
					burst = $urandom_range(1, 24);
					pick  = $urandom_range(0, 9);
					if (pick == 0)
						drain();
					else if (pick > 2)
						hold_off($urandom_range(1, 100));
				end
				burst--;

				pick = $urandom_range(0, 99);
				id   = (pick < 8) ? ID_BITS'($urandom)
					: pool + ID_BITS'($urandom_range(0, span - 1));

				trace_pos = trace_pos + 1'b1;
				ct = ($urandom_range(0, 19) == 0) ? TIME_BITS'($urandom) : trace_pos;

				pick = $urandom_range(0, 99);
				if (pick < 8)
					nu = '1;
				else if (pick < 14)
					nu = $urandom;
				else if (pick < 24)
					nu = tie_base + TIME_BITS'($urandom_range(0, 2));
				else
					nu = trace_pos + TIME_BITS'($urandom_range(1, 3 * span));
				access(id, ct, nu);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/boe_pkg.sv
hdl/boe_entry_store.sv
hdl/boe_seen_map.sv
hdl/boe_ctrl.sv
hdl/belady_opt_cache_engine.sv
hdl/boe_checker.sv
test/boe_opt_checker.sv
test/tb_belady_opt_cache_engine.sv
